// ===== hdl/arcm_pkg.sv =====
package arcm_pkg;

   localparam int MAP_DEPTH_DEF = 256;
   localparam int QUEUE_DEPTH   = 4;

   // configuration register indexes
   localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;
   localparam logic [2:0] REG_GREY_MODE    = 3'd1;
   localparam logic [2:0] REG_MAP_SIZE     = 3'd2;
   localparam logic [2:0] REG_AUTO_RANGE   = 3'd3;
   localparam logic [2:0] REG_MANUAL_MIN   = 3'd4;
   localparam logic [2:0] REG_MANUAL_MAX   = 3'd5;

   localparam logic [1:0] FMT_MONO8   = 2'd0;
   localparam logic [1:0] FMT_MONO16B = 2'd1;
   localparam logic [1:0] FMT_MONO16W = 2'd2;
   localparam logic [1:0] FMT_RGB24   = 2'd3;

   typedef enum logic [2:0] {
      K_WRITE   = 3'd0,
      K_FIXED   = 3'd1,
      K_DIRECT  = 3'd2,
      K_FALSE   = 3'd3,
      K_GREYDIV = 3'd4
   } kind_type;

   typedef struct packed {
      logic [1:0]  pixel_format;
      logic        grey_mode;
      logic [8:0]  map_size;
      logic        auto_range;
      logic [15:0] manual_min;
      logic [15:0] manual_max;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] value;
      logic [31:0] word;
      logic        last;
   } work_type;

   function automatic logic [31:0] grey_word(input logic [7:0] g);
      grey_word = {8'hFF, g, g, g};
   endfunction

endpackage

// ===== hdl/arcm_front.sv =====
module arcm_front
   import arcm_pkg::*;
(
   input  cfg_type     cfg,
   input  logic        cmd,
   input  logic [15:0] sample,
   input  logic [7:0]  red,
   input  logic [7:0]  green,
   input  logic [7:0]  blue,
   input  logic        last_pixel,
   input  logic [7:0]  map_index,
   input  logic [31:0] map_color,
   output work_type    work
);

   logic [26:0] luma_grey;
   logic [26:0] luma_false;

   // Q16 luma weights, plain and times 2.2
   assign luma_grey  = 27'(19588 * red) + 27'(38470 * green) + 27'(7471 * blue);
   assign luma_false = 27'(43095 * red) + 27'(84633 * green) + 27'(16436 * blue);

   always_comb begin
      work.kind  = K_FALSE;
      work.value = sample;
      work.word  = map_color;
      work.last  = last_pixel;
      if (cmd) begin
         work.kind  = K_WRITE;
         work.value = {8'd0, map_index};
      end else begin
         case (cfg.pixel_format)
            FMT_RGB24: begin
               work.kind = K_FIXED;
               if (cfg.grey_mode) begin
                  work.value = {5'd0, luma_grey[26:16]};
                  work.word  = grey_word(luma_grey[23:16]);
               end else begin
                  work.value = {5'd0, luma_false[26:16]};
                  work.word  = {8'hFF, red, green, blue};
               end
            end
            FMT_MONO16W: begin
               work.kind = cfg.grey_mode ? K_GREYDIV : K_FALSE;
            end
            FMT_MONO8: begin
               work.value = {8'd0, sample[7:0]};
               work.kind  = cfg.grey_mode ? K_DIRECT : K_FALSE;
            end
            default: begin
               if (cfg.grey_mode) begin
                  work.value = {8'd0, sample[15:8]};
                  work.kind  = K_DIRECT;
               end
            end
         endcase
      end
   end

endmodule

// ===== hdl/arcm_queue.sv =====
module arcm_queue
   import arcm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output work_type head,
   output logic     empty
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   work_type          entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/arcm_back.sv =====
module arcm_back
   import arcm_pkg::*;
#(
   parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  work_type    head,
   input  logic        head_empty,
   output logic        head_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [31:0] rsp_pixel_color,
   output logic [15:0] rsp_frame_min,
   output logic [15:0] rsp_frame_max,
   output logic        rsp_frame_end
);

   localparam int AW = $clog2(MAP_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_IDX  = 6'b001000,
      ST_READ = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   logic [31:0] map_mem [MAP_DEPTH];

   state_type   state_ff, state_in;
   logic [31:0] range_low_ff, range_low_in;
   logic [31:0] range_high_ff, range_high_in;
   logic [15:0] run_min_ff, run_min_in;
   logic [15:0] run_max_ff, run_max_in;
   kind_type    kind_ff, kind_in;
   logic [15:0] value_ff, value_in;
   logic [31:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  step_ff, step_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [31:0] rd_data_ff;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_color_ff, out_color_in;
   logic [15:0] out_min_ff, out_min_in;
   logic [15:0] out_max_ff, out_max_in;
   logic        out_end_ff, out_end_in;

   logic [8:0]  size_eff;
   logic [31:0] diff;
   logic [32:0] rem_shift;
   logic [15:0] new_min, new_max;
   logic        take, finish, mem_we;
   logic [31:0] fin_color;

   assign diff = range_high_ff - range_low_ff;
   assign rem_shift = {rem_ff, quot_ff[31]};
   assign new_min = (head.value < run_min_ff) ? head.value : run_min_ff;
   assign new_max = (head.value > run_max_ff) ? head.value : run_max_ff;

   always_comb begin
      if (cfg.map_size < 9'd2) begin
         size_eff = 9'd2;
      end else if (32'(cfg.map_size) > 32'(MAP_DEPTH)) begin
         size_eff = 9'(MAP_DEPTH);
      end else begin
         size_eff = cfg.map_size;
      end
   end

   assign take = (state_ff == ST_IDLE) && !head_empty &&
                 (head.kind == K_WRITE || !out_valid_ff || rsp_pop);
   assign head_pop = take;
   assign mem_we = take && head.kind == K_WRITE && 32'(head.value) < 32'(MAP_DEPTH);

   always_comb begin
      state_in      = state_ff;
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      run_min_in    = run_min_ff;
      run_max_in    = run_max_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      addr_in       = addr_ff;
      out_color_in  = out_color_ff;
      out_min_in    = out_min_ff;
      out_max_in    = out_max_ff;
      out_end_in    = out_end_ff;
      finish        = 1'b0;
      fin_color     = rd_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (take && head.kind != K_WRITE) begin
               kind_in    = head.kind;
               value_in   = head.value;
               out_min_in = new_min;
               out_max_in = new_max;
               out_end_in = head.last;
               if (head.last) begin
                  run_min_in = 16'hFFFF;
                  run_max_in = 16'd0;
               end else begin
                  run_min_in = new_min;
                  run_max_in = new_max;
               end
               case (head.kind)
                  K_FIXED: begin
                     finish    = 1'b1;
                     fin_color = head.word;
                  end
                  K_DIRECT: begin
                     addr_in  = (32'(head.value) >= 32'(MAP_DEPTH)) ?
                                AW'(MAP_DEPTH - 1) : AW'(head.value);
                     state_in = ST_READ;
                  end
                  default: state_in = ST_MUL;
               endcase
            end
         end
         ST_MUL: begin
            if (kind_ff == K_GREYDIV) begin
               quot_in = 32'(value_ff) * 32'd255;
            end else begin
               quot_in = (32'(value_ff) - range_low_ff) * 32'(size_eff - 9'd1);
            end
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_shift >= {1'b0, diff}) begin
               rem_in  = 32'(rem_shift - {1'b0, diff});
               quot_in = {quot_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_shift[31:0];
               quot_in = {quot_ff[30:0], 1'b0};
            end
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd31) begin
               state_in = ST_IDX;
            end
         end
         ST_IDX: begin
            // a zero divisor leaves an all-ones quotient, which saturates below
            if (kind_ff == K_GREYDIV) begin
               finish    = 1'b1;
               fin_color = grey_word((quot_ff > 32'd255) ? 8'hFF : quot_ff[7:0]);
            end else begin
               addr_in  = (quot_ff >= 32'(size_eff)) ? AW'(32'(size_eff) - 32'd1) :
                          AW'(quot_ff);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            finish = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase

      if (finish) begin
         state_in     = ST_IDLE;
         out_color_in = fin_color;
         if (out_end_in) begin
            if (cfg.auto_range) begin
               range_low_in  = 32'(out_min_in);
               range_high_in = 32'(out_max_in);
               if (out_min_in == out_max_in) begin
                  range_low_in  = 32'(out_min_in) - 32'd1;
                  range_high_in = 32'(out_max_in) + 32'd1;
               end
            end else begin
               if (cfg.manual_max >= cfg.manual_min) begin
                  range_low_in  = 32'(cfg.manual_min);
                  range_high_in = 32'(cfg.manual_max);
               end else begin
                  range_low_in  = 32'(cfg.manual_max);
                  range_high_in = 32'(cfg.manual_min);
               end
               if (cfg.manual_max == cfg.manual_min) begin
                  range_high_in = 32'(cfg.manual_min) + 32'd1000;
               end
            end
         end
      end

      if (finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         range_low_ff  <= '0;
         range_high_ff <= '1;
         run_min_ff    <= 16'hFFFF;
         run_max_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
         run_min_ff    <= run_min_in;
         run_max_ff    <= run_max_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      value_ff     <= value_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      addr_ff      <= addr_in;
      out_color_ff <= out_color_in;
      out_min_ff   <= out_min_in;
      out_max_ff   <= out_max_in;
      out_end_ff   <= out_end_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[AW'(head.value)] <= head.word;
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= map_mem[addr_ff];
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_frame_min   = out_min_ff;
   assign rsp_frame_max   = out_max_ff;
   assign rsp_frame_end   = out_end_ff;

endmodule

// ===== hdl/auto_ranging_false_color_mapper.sv =====
// channel   | direction | handshake         | payload
// req_      | in        | req_push/req_full | cmd sample red green blue last_pixel
//           |           |                   | map_index map_color
// rsp_      | out       | rsp_pop/rsp_empty | pixel_color frame_min frame_max frame_end
// csr_      | in        | csr_we            | csr_index csr_wdata
//
// Colormap writes retire when taken and rgb pixels finish from idle; direct grey
// lookups go through read and finish. False-color pixels go through multiply, the
// 32-step shared divider, index, read and finish; scaled-grey ones end at index.
// A 4-entry queue decouples input from the back end. Reset is synchronous; the
// colormap has no reset value. A stalled result blocks pixels; the queue still fills.
module auto_ranging_false_color_mapper
   import arcm_pkg::*;
#(
   parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [15:0] req_sample,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_last_pixel,
   input  logic [7:0]  req_map_index,
   input  logic [31:0] req_map_color,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_pixel_color,
   output logic [15:0] rsp_frame_min,
   output logic [15:0] rsp_frame_max,
   output logic        rsp_frame_end,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   work_type front_work;
   work_type head;
   logic     head_empty, head_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_PIXEL_FORMAT: cfg_in.pixel_format = csr_wdata[1:0];
            REG_GREY_MODE:    cfg_in.grey_mode    = csr_wdata[0];
            REG_MAP_SIZE:     cfg_in.map_size     = csr_wdata[8:0];
            REG_AUTO_RANGE:   cfg_in.auto_range   = csr_wdata[0];
            REG_MANUAL_MIN:   cfg_in.manual_min   = csr_wdata;
            REG_MANUAL_MAX:   cfg_in.manual_max   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format <= FMT_MONO8;
         cfg_ff.grey_mode    <= 1'b0;
         cfg_ff.map_size     <= 9'd256;
         cfg_ff.auto_range   <= 1'b1;
         cfg_ff.manual_min   <= 16'd0;
         cfg_ff.manual_max   <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   arcm_front u_front (
      .cfg        (cfg_ff),
      .cmd        (req_cmd),
      .sample     (req_sample),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .last_pixel (req_last_pixel),
      .map_index  (req_map_index),
      .map_color  (req_map_color),
      .work       (front_work)
   );

   arcm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_work),
      .full      (req_full),
      .pop       (head_pop),
      .head      (head),
      .empty     (head_empty)
   );

   arcm_back #(.MAP_DEPTH(MAP_DEPTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head            (head),
      .head_empty      (head_empty),
      .head_pop        (head_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_frame_min   (rsp_frame_min),
      .rsp_frame_max   (rsp_frame_max),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

// ===== hdl/arcm_checker.sv =====
module arcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_pixel_color,
   input logic [15:0] rsp_frame_min,
   input logic [15:0] rsp_frame_max
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present right after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("result dropped without transfer");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_frame_min <= rsp_frame_max)
      else $error("frame min above frame max");

   a_payload_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_pixel_color))
      else $error("stalled color changed");

endmodule

bind auto_ranging_false_color_mapper arcm_checker u_arcm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_frame_min   (rsp_frame_min),
   .rsp_frame_max   (rsp_frame_max)
);

// ===== tb/arcm_checker.sv =====
`timescale 1ns / 100ps

module arcm_scoreboard
   import arcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_cmd,
   input  logic [15:0] req_sample,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_last_pixel,
   input  logic [7:0]  req_map_index,
   input  logic [31:0] req_map_color,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [31:0] rsp_pixel_color,
   input  logic [15:0] rsp_frame_min,
   input  logic [15:0] rsp_frame_max,
   input  logic        rsp_frame_end,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          failures,
   output int          pending,
   output int          pixels_seen
);

   localparam int DEPTH = MAP_DEPTH_DEF;

   typedef struct packed {
      logic [31:0] color;
      logic [15:0] fmin;
      logic [15:0] fmax;
      logic        fend;
   } pixel_result_type;

   pixel_result_type expected_pixels[$];

   logic [31:0] lut [DEPTH];
   logic [31:0] lo_bound, hi_bound;
   logic [31:0] seen_min, seen_max;
   logic [1:0]  fmt;
   logic        grey;
   logic [8:0]  msize;
   logic        autor;
   logic [15:0] man_lo, man_hi;

   function automatic logic [31:0] grey_argb(input logic [31:0] g);
      return {8'hFF, g[7:0], g[7:0], g[7:0]};
   endfunction

   function automatic logic [31:0] lut_read(input logic [31:0] idx);
      if (idx >= DEPTH) idx = DEPTH - 1;
      return lut[idx];
   endfunction

   function automatic logic [31:0] scaled_lookup(input logic [31:0] v);
      logic [31:0] s, d, i;
      s = 32'(msize);
      if (s < 2) s = 2;
      if (s > DEPTH) s = DEPTH;
      d = hi_bound - lo_bound;
      if (d == 0) begin
         i = s - 1;
      end else begin
         i = ((v - lo_bound) * (s - 1)) / d;
         if (i >= s) i = s - 1;
      end
      return lut_read(i);
   endfunction

   // expected result for one pixel transfer; also advances frame statistics
   function automatic pixel_result_type map_pixel(input logic [15:0] smp,
                                                  input logic [7:0] r,
                                                  input logic [7:0] g, input logic [7:0] b,
                                                  input logic last);
      pixel_result_type res;
      logic [31:0] v, col, d, gl, r32, g32, b32;
      r32 = {24'd0, r};
      g32 = {24'd0, g};
      b32 = {24'd0, b};
      if (fmt == FMT_RGB24) begin
         if (grey) begin
            v = (32'd19588 * r32 + 32'd38470 * g32 + 32'd7471 * b32) >> 16;
            col = grey_argb(v);
         end else begin
            v = (32'd43095 * r32 + 32'd84633 * g32 + 32'd16436 * b32) >> 16;
            col = {8'hFF, r, g, b};
         end
      end else if (fmt == FMT_MONO16W) begin
         v = {16'd0, smp};
         if (grey) begin
            d = hi_bound - lo_bound;
            gl = (d == 0) ? 32'd255 : (v * 32'd255) / d;
            if (gl > 255) gl = 255;
            col = grey_argb(gl);
         end else begin
            col = scaled_lookup(v);
         end
      end else begin
         if (fmt == FMT_MONO8) v = {24'd0, smp[7:0]};
         else if (grey) v = {24'd0, smp[15:8]};
         else v = {16'd0, smp};
         col = grey ? lut_read(v) : scaled_lookup(v);
      end
      if (v > seen_max) seen_max = v;
      if (v < seen_min) seen_min = v;
      res.color = col;
      res.fmin = seen_min[15:0];
      res.fmax = seen_max[15:0];
      res.fend = last;
      if (last) begin
         if (autor) begin
            lo_bound = seen_min;
            hi_bound = seen_max;
            if (hi_bound == lo_bound) begin
               hi_bound = hi_bound + 1;
               lo_bound = lo_bound - 1;
               if (hi_bound > 32'hFFFF_FFFE) hi_bound = 32'hFFFF_FFFE;
            end
         end else begin
            if (man_hi >= man_lo) begin
               hi_bound = {16'd0, man_hi};
               lo_bound = {16'd0, man_lo};
            end else begin
               hi_bound = {16'd0, man_lo};
               lo_bound = {16'd0, man_hi};
            end
            if (hi_bound == lo_bound) hi_bound = lo_bound + 1000;
         end
         seen_min = 65535;
         seen_max = 0;
      end
      return res;
   endfunction

   assign pending = expected_pixels.size();

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         lo_bound = 0;
         hi_bound = 32'hFFFF_FFFF;
         seen_min = 65535;
         seen_max = 0;
         fmt = FMT_MONO8;
         grey = 1'b0;
         msize = 9'd256;
         autor = 1'b1;
         man_lo = 16'd0;
         man_hi = 16'hFFFF;
         failures = 0;
         pixels_seen = 0;
         expected_pixels.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: result transfer with nothing expected, color %h",
                        $time, rsp_pixel_color);
               failures = failures + 1;
            end else begin
               want = expected_pixels.pop_front();
               pixels_seen = pixels_seen + 1;
               if (want.color !== rsp_pixel_color) begin
                  $display("%0t: pixel_color expected %h actual %h",
                           $time, want.color, rsp_pixel_color);
                  failures = failures + 1;
               end
               if (want.fmin !== rsp_frame_min) begin
                  $display("%0t: frame_min expected %0d actual %0d",
                           $time, want.fmin, rsp_frame_min);
                  failures = failures + 1;
               end
               if (want.fmax !== rsp_frame_max) begin
                  $display("%0t: frame_max expected %0d actual %0d",
                           $time, want.fmax, rsp_frame_max);
                  failures = failures + 1;
               end
               if (want.fend !== rsp_frame_end) begin
                  $display("%0t: frame_end expected %0b actual %0b",
                           $time, want.fend, rsp_frame_end);
                  failures = failures + 1;
               end
            end
         end
         if (req_push && !req_full) begin
            if (req_cmd) begin
               lut[req_map_index] = req_map_color;
            end else begin
               expected_pixels.push_back(map_pixel(req_sample, req_red, req_green,
                                                   req_blue, req_last_pixel));
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_PIXEL_FORMAT: fmt = csr_wdata[1:0];
               REG_GREY_MODE:    grey = csr_wdata[0];
               REG_MAP_SIZE:     msize = csr_wdata[8:0];
               REG_AUTO_RANGE:   autor = csr_wdata[0];
               REG_MANUAL_MIN:   man_lo = csr_wdata;
               REG_MANUAL_MAX:   man_hi = csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import arcm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 60;

   logic        clock, reset;
   logic        req_push, req_full, req_cmd, req_last_pixel;
   logic [15:0] req_sample;
   logic [7:0]  req_red, req_green, req_blue, req_map_index;
   logic [31:0] req_map_color;
   logic        rsp_empty, rsp_pop, rsp_frame_end;
   logic [31:0] rsp_pixel_color;
   logic [15:0] rsp_frame_min, rsp_frame_max;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int failures, pending, pixels_seen;
   int sender_idle_pct, receiver_idle_pct;
   int items_sent, frames_sent;
   int cycles;
   bit hold_off_request;

   auto_ranging_false_color_mapper DUT (.*);

   arcm_scoreboard u_checker (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles = cycles + 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // receiver: random pop, plus one long hold-off on request
   initial begin
      int hold_count;
      bit hold_taken;
      rsp_pop = 0;
      hold_count = 0;
      hold_taken = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_taken) begin
            hold_count = 300;
            hold_taken = 1;
         end
         if (hold_count > 0) begin
            hold_count = hold_count - 1;
            rsp_pop <= 0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   task automatic send_req(input logic cmd, input logic [15:0] smp, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b, input logic last,
                           input logic [7:0] idx, input logic [31:0] color);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_cmd <= cmd;
      req_sample <= smp;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      req_last_pixel <= last;
      req_map_index <= idx;
      req_map_color <= color;
      req_push <= 1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      items_sent = items_sent + 1;
      if (!cmd && last) frames_sent = frames_sent + 1;
   endtask

   task automatic send_pixel(input logic [15:0] smp, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic last);
      send_req(1'b0, smp, r, g, b, last, 8'($urandom), $urandom);
   endtask

   task automatic send_map_entry(input logic [7:0] idx, input logic [31:0] color);
      send_req(1'b1, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               1'($urandom), idx, color);
   endtask

   // pause the sender until the block has drained
   task automatic wait_idle();
      req_push <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic set_mode(input logic [1:0] f, input logic gm, input logic [8:0] ms);
      wait_idle();
      write_reg(REG_PIXEL_FORMAT, {14'd0, f});
      write_reg(REG_GREY_MODE, {15'd0, gm});
      write_reg(REG_MAP_SIZE, {7'd0, ms});
   endtask

   task automatic random_frame(input int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(19) == 0) send_map_entry(8'($urandom), $urandom);
         send_pixel(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), i == len - 1);
      end
   endtask

   initial begin
      logic [8:0]  ms;
      logic [15:0] mlo, mhi;
      reset = 1;
      req_push = 0;
      req_cmd = 0;
      req_sample = 0;
      req_red = 0;
      req_green = 0;
      req_blue = 0;
      req_last_pixel = 0;
      req_map_index = 0;
      req_map_color = 0;
      csr_we = 0;
      csr_index = REG_PIXEL_FORMAT;
      csr_wdata = 0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      hold_off_request = 0;
      items_sent = 0;
      frames_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // fill the whole colormap so no lookup hits an unwritten entry
      for (int i = 0; i < MAP_DEPTH_DEF; i++) send_map_entry(8'(i), $urandom);

      // directed: reset range, false color mono8 extremes
      send_pixel(16'h0000, 8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b1);
      // single-value frame widens the range
      send_pixel(16'h0042, 8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(16'h0042, 8'd0, 8'd0, 8'd0, 1'b1);
      set_mode(FMT_MONO16B, 1'b1, 9'd0);
      send_pixel(16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(16'h00FF, 8'd0, 8'd0, 8'd0, 1'b1);
      set_mode(FMT_MONO16B, 1'b0, 9'd1);
      send_pixel(16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(16'h0000, 8'd0, 8'd0, 8'd0, 1'b1);
      set_mode(FMT_MONO16W, 1'b0, 9'd511);
      send_pixel(16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(16'h0001, 8'd0, 8'd0, 8'd0, 1'b1);
      wait_idle();
      write_reg(REG_AUTO_RANGE, 16'd0);
      write_reg(REG_MANUAL_MIN, 16'd5000);
      write_reg(REG_MANUAL_MAX, 16'd5000);
      send_pixel(16'h8000, 8'd0, 8'd0, 8'd0, 1'b1);
      set_mode(FMT_MONO16W, 1'b1, 9'd2);
      send_pixel(16'd6000, 8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b1);
      wait_idle();
      write_reg(REG_MANUAL_MIN, 16'hFFFF);
      write_reg(REG_MANUAL_MAX, 16'h0000);
      send_pixel(16'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      set_mode(FMT_RGB24, 1'b0, 9'd256);
      send_pixel(16'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(16'd0, 8'h00, 8'h00, 8'h00, 1'b1);
      set_mode(FMT_RGB24, 1'b1, 9'd256);
      write_reg(REG_AUTO_RANGE, 16'd1);
      send_pixel(16'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(16'd0, 8'h12, 8'h80, 8'hFE, 1'b1);

      // random frames under changing settings and idling
      while (items_sent < 1750) begin
         if (items_sent < 800) begin
            sender_idle_pct = 35;
            receiver_idle_pct = 80;
         end else if (items_sent < 1300) begin
            sender_idle_pct = 80;
            receiver_idle_pct = 35;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         case ($urandom_range(3))
            0: ms = 9'd2;
            1: ms = 9'd256;
            2: ms = 9'($urandom);
            default: ms = 9'($urandom_range(256, 2));
         endcase
         set_mode(2'($urandom), 1'($urandom), ms);
         write_reg(REG_AUTO_RANGE, {15'd0, $urandom_range(3) != 0});
         mlo = 16'($urandom);
         mhi = ($urandom_range(4) == 0) ? mlo : 16'($urandom);
         write_reg(REG_MANUAL_MIN, mlo);
         write_reg(REG_MANUAL_MAX, mhi);
         if (items_sent > 1450 && !hold_off_request) begin
            hold_off_request = 1;
            random_frame(20);
         end
         for (int k = $urandom_range(3, 1); k > 0; k--) begin
            random_frame(($urandom_range(3) == 0) ? 1 : $urandom_range(40, 2));
         end
      end

      req_push <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      $display("covered %0d transfers in, %0d frames, %0d pixel results checked",
               items_sent, frames_sent, pixels_seen);
      $display("all four formats, grey and false color, auto and manual range, stalls");
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== auto_ranging_false_color_mapper.f =====
hdl/arcm_pkg.sv
hdl/arcm_front.sv
hdl/arcm_queue.sv
hdl/arcm_back.sv
hdl/auto_ranging_false_color_mapper.sv
hdl/arcm_checker.sv
tb/arcm_checker.sv
tb/testbench.sv
